// ===== hw/rtl/trihist_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trihist_pkg
// Shared constants, command/status types and the gray conversion for the
// triangle threshold histogram block.
// ----------------------------------------------------------------------------
package trihist_pkg;

   localparam int CountWidth = 24;
   localparam int BinWidth   = 8;
   localparam int NumBins    = 256;
   localparam int ColorWidth = 24;
   localparam int DeltaWidth = CountWidth + 1;
   localparam int DxWidth    = BinWidth + 1;
   localparam int ProdWidth  = DeltaWidth + DxWidth;
   localparam int DiffWidth  = ProdWidth + 1;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   localparam logic [BinWidth-1:0]   MidBin   = BinWidth'(128);
   localparam logic [BinWidth-1:0]   TopBin   = BinWidth'(255);
   localparam logic [BinWidth-1:0]   LowBin   = '0;

   typedef struct packed {
      logic                rd_en;
      logic [BinWidth-1:0] rd_addr;
      logic                dist_mode;
      logic                setup;
      logic                clear;
   } trihist_cmd_type;

   typedef struct packed {
      logic                busy;
      logic [BinWidth-1:0] lo;
      logic [BinWidth-1:0] hi;
   } trihist_status_type;

   function automatic logic [BinWidth-1:0] gray_level(input logic [ColorWidth-1:0] rgb);
      logic [12:0] sum;
      sum = 13'(rgb[23:16]) * 13'd11 + 13'(rgb[15:8]) * 13'd16 + 13'(rgb[7:0]) * 13'd5;
      return sum[12:5];
   endfunction

endpackage

// ===== hw/rtl/triangle_histogram_threshold_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_histogram_threshold_top
// Triangle threshold over a frame of RGB pixels: gray histogram, peak and
// edge search, and the first bin of largest triangle distance.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_pixel_color[23:0], req_last_pixel
//  rsp      out        rsp_valid/rsp_stall  rsp_threshold_level[7:0]
//
// pixels are accepted back to back while req_stall is low; the histogram
// update forwards back-to-back hits. after the last pixel, rsp_valid waits on
// two passes over the single read port of the histogram memory
// reset is synchronous; per-bin valid flops clear the histogram at once
// req_stall is high from the last pixel transfer until the result transfer
// ----------------------------------------------------------------------------
module triangle_histogram_threshold_top
   import trihist_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ColorWidth-1:0] req_pixel_color,
   input  logic                  req_last_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BinWidth-1:0]   rsp_threshold_level
);

   trihist_cmd_type    cmd;
   trihist_status_type status;
   logic               px_accept;

   assign px_accept = req_valid && !req_stall;

   trihist_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_last_pixel (req_last_pixel),
      .req_stall      (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .status         (status),
      .cmd            (cmd)
   );

   trihist_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .px_accept           (px_accept),
      .req_pixel_color     (req_pixel_color),
      .cmd                 (cmd),
      .status              (status),
      .rsp_threshold_level (rsp_threshold_level)
   );

endmodule

// ===== hw/rtl/trihist_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trihist_dp
// Histogram memory with read-modify-write forwarding, peak search and the
// pipelined triangle distance scan.
// ----------------------------------------------------------------------------
module trihist_dp
   import trihist_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    px_accept,
   input  logic [ColorWidth-1:0]   req_pixel_color,
   input  trihist_cmd_type         cmd,
   output trihist_status_type      status,
   output logic [BinWidth-1:0]     rsp_threshold_level
);

   logic [CountWidth-1:0] mem [NumBins];
   logic [NumBins-1:0]    vld_ff;
   logic [CountWidth-1:0] rd_q_ff;
   logic                  rd_v_ff;
   logic [BinWidth-1:0]   rd_addr;

   // pixel update stage
   logic                  u_vld_ff;
   logic [BinWidth-1:0]   u_addr_ff;
   logic                  wr_vld_ff;
   logic [BinWidth-1:0]   wr_addr_ff;
   logic [CountWidth-1:0] wr_data_ff;
   logic [CountWidth-1:0] cur_cnt;
   logic [CountWidth-1:0] nxt_cnt;

   // scan pipeline
   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic                  s1_dist_ff;
   logic [BinWidth-1:0]   idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [CountWidth-1:0] h1;

   logic [BinWidth-1:0]   peak_ff;
   logic [CountWidth-1:0] peak_val_ff;
   logic [CountWidth-1:0] h_lo_ff;
   logic [CountWidth-1:0] h_hi_ff;

   logic [BinWidth-1:0]          edge_bin_ff;
   logic [CountWidth-1:0]        hedge_ff;
   logic signed [DxWidth-1:0]    dx_ff;
   logic signed [DeltaWidth-1:0] dy_ff;
   logic signed [DxWidth-1:0]    di;
   logic signed [DeltaWidth-1:0] dh;

   logic signed [ProdWidth-1:0]  pa_ff, pb_ff;
   logic signed [DiffWidth-1:0]  diff_ff;
   logic [DiffWidth-1:0]         dist_ff;
   logic [DiffWidth-1:0]         best_dist_ff;
   logic [BinWidth-1:0]          best_idx_ff;
   logic                         best_vld_ff;
   logic                         peak_low;

   assign rd_addr = px_accept ? gray_level(req_pixel_color) : cmd.rd_addr;

   // the previous update lands at the same edge as this entry's read
   always_comb begin
      if (wr_vld_ff && (wr_addr_ff == u_addr_ff)) begin
         cur_cnt = wr_data_ff;
      end else if (rd_v_ff) begin
         cur_cnt = rd_q_ff;
      end else begin
         cur_cnt = '0;
      end
      nxt_cnt = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + CountWidth'(1);
   end

   always_ff @(posedge clock) begin
      if (u_vld_ff) begin
         mem[u_addr_ff] <= nxt_cnt;
      end
      rd_q_ff <= mem[rd_addr];
      rd_v_ff <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vld_ff <= '0;
      end else if (u_vld_ff) begin
         vld_ff[u_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u_vld_ff  <= 1'b0;
         wr_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         u_vld_ff  <= px_accept;
         wr_vld_ff <= u_vld_ff;
         s1_vld_ff <= cmd.rd_en;
         s2_vld_ff <= s1_vld_ff && s1_dist_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      u_addr_ff  <= rd_addr;
      wr_addr_ff <= u_addr_ff;
      wr_data_ff <= nxt_cnt;
      s1_dist_ff <= cmd.dist_mode;
      idx1_ff    <= cmd.rd_addr;
      idx2_ff    <= idx1_ff;
      idx3_ff    <= idx2_ff;
      idx4_ff    <= idx3_ff;
   end

   assign h1 = rd_v_ff ? rd_q_ff : '0;

   // peak search, first highest bin wins
   always_ff @(posedge clock) begin
      if (s1_vld_ff && !s1_dist_ff) begin
         if ((idx1_ff == LowBin) || (h1 > peak_val_ff)) begin
            peak_ff     <= idx1_ff;
            peak_val_ff <= h1;
         end
         if (idx1_ff == LowBin) begin
            h_lo_ff <= h1;
         end
         if (idx1_ff == TopBin) begin
            h_hi_ff <= h1;
         end
      end
   end

   assign peak_low = (peak_ff < MidBin);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         edge_bin_ff <= peak_low ? TopBin : LowBin;
         hedge_ff    <= peak_low ? h_hi_ff : h_lo_ff;
         dx_ff       <= signed'({1'b0, peak_ff}) -
                        signed'({1'b0, (peak_low ? TopBin : LowBin)});
         dy_ff       <= signed'({1'b0, peak_val_ff}) -
                        signed'({1'b0, (peak_low ? h_hi_ff : h_lo_ff)});
      end
   end

   assign di = signed'({1'b0, idx1_ff}) - signed'({1'b0, edge_bin_ff});
   assign dh = signed'({1'b0, h1}) - signed'({1'b0, hedge_ff});

   // distance pipeline: products, difference, magnitude, compare
   always_ff @(posedge clock) begin
      pa_ff   <= ProdWidth'(dy_ff) * ProdWidth'(di);
      pb_ff   <= ProdWidth'(dx_ff) * ProdWidth'(dh);
      diff_ff <= DiffWidth'(pa_ff) - DiffWidth'(pb_ff);
      dist_ff <= diff_ff[DiffWidth-1] ? DiffWidth'(-diff_ff) : DiffWidth'(diff_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.setup) begin
         best_vld_ff <= 1'b0;
      end else if (s4_vld_ff && (!best_vld_ff || (dist_ff > best_dist_ff))) begin
         best_vld_ff <= 1'b1;
      end
      if (s4_vld_ff && (!best_vld_ff || (dist_ff > best_dist_ff))) begin
         best_dist_ff <= dist_ff;
         best_idx_ff  <= idx4_ff;
      end
   end

   assign status.busy = s1_vld_ff | s2_vld_ff | s3_vld_ff | s4_vld_ff;
   assign status.lo   = peak_low ? peak_ff : LowBin;
   assign status.hi   = peak_low ? TopBin : peak_ff;

   assign rsp_threshold_level = best_idx_ff;

endmodule

// ===== hw/rtl/trihist_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trihist_ctrl
// Sequencer for pixel collection, peak scan, distance scan and result
// handoff.
// ----------------------------------------------------------------------------
module trihist_ctrl
   import trihist_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_last_pixel,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  trihist_status_type status,
   output trihist_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_FLUSH,
      ST_PEAK,
      ST_PEAK_DRAIN,
      ST_SETUP,
      ST_DIST,
      ST_DIST_DRAIN,
      ST_RESULT
   } state_type;

   state_type           state_ff, state_in;
   logic [BinWidth-1:0] ctr_ff, ctr_in;
   logic                req_stall_ff;
   logic                rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctr_in   = ctr_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid && !req_stall_ff && req_last_pixel) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_PEAK;
            ctr_in   = LowBin;
         end
         ST_PEAK: begin
            ctr_in = ctr_ff + BinWidth'(1);
            if (ctr_ff == TopBin) begin
               state_in = ST_PEAK_DRAIN;
            end
         end
         ST_PEAK_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_DIST;
            ctr_in   = status.lo;
         end
         ST_DIST: begin
            if (ctr_ff == status.hi) begin
               state_in = ST_DIST_DRAIN;
            end else begin
               ctr_in = ctr_ff + BinWidth'(1);
            end
         end
         ST_DIST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         ctr_ff       <= '0;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         req_stall_ff <= (state_in != ST_COLLECT);
         rsp_valid_ff <= (state_in == ST_RESULT);
      end
   end

   always_comb begin
      cmd.rd_en     = (state_ff == ST_PEAK) || (state_ff == ST_DIST);
      cmd.rd_addr   = ctr_ff;
      cmd.dist_mode = (state_ff == ST_DIST);
      cmd.setup     = (state_ff == ST_SETUP);
      // histogram is wiped while the result waits
      cmd.clear     = (state_ff == ST_RESULT);
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_result_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall_ff)
      else $error("result pending while input open");

   a_last_closes_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall_ff && req_last_pixel) |=> req_stall_ff)
      else $error("input still open after last pixel transfer");

   a_dist_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIST) |-> ((ctr_ff >= status.lo) && (ctr_ff <= status.hi)))
      else $error("distance scan outside peak/edge span");

   a_drained_before_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !status.busy)
      else $error("result shown while scan pipeline busy");
`endif

endmodule
